### rtl/gps_pkg.sv
`timescale 1ns / 1ps
package gps_pkg;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_SPACING = 1'b0;
  localparam logic REG_CATCH_RANGE = 1'b1;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;

  // Top-level sequencer states.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCALE = 3'b010,
    S_REM   = 3'b100
  } top_state_t;

  // Decade search states.
  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_DIV   = 3'b100
  } dec_state_t;

  // Status from the decade search.
  typedef struct packed {
    logic done;
    logic ok;
  } dec_status_t;

  // Status from one remainder lane.
  typedef struct packed {
    logic done;
    logic found;
  } lane_status_t;

endpackage

### rtl/gps_decade.sv
`timescale 1ns / 1ps
module gps_decade import gps_pkg::*; #(
  parameter int MAX_STEPS = 12,
  parameter int FRAC_BITS = 16,
  parameter int NB = 5,
  parameter int ZW = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [31:0]   scale,
  input  logic [15:0]   max_spacing,
  output dec_status_t   status,
  output logic [ZW-1:0] pitch
);

  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;

  dec_state_t    st;
  logic [ZW-1:0] z;
  logic [SW-1:0] steps;
  logic [BW-1:0] bcnt;
  logic [3:0]    rem;

  // Window bounds derived from max_spacing.
  logic [31:0]   ms_prod;
  logic [12:0]   ms_div10;
  logic [ZW-1:0] hi;
  logic [ZW-1:0] lo;
  logic          lo_en;
  logic          over;
  logic          under;
  logic          exhausted;

  assign ms_prod   = 32'(max_spacing) * 32'd52429;
  assign ms_div10  = ms_prod[31:19];
  assign hi        = ZW'(max_spacing) << FRAC_BITS;
  assign lo        = ZW'(ms_div10 - 13'd1) << FRAC_BITS;
  assign lo_en     = (ms_div10 != 13'd0);
  assign over      = (z > hi);
  assign under     = lo_en && (z < lo);
  assign exhausted = (steps >= SW'(MAX_STEPS));

  // One byte of the divide by ten per cycle, most significant first.
  logic [11:0] cur;
  logic [23:0] qprod;
  logic [7:0]  qb;
  logic [11:0] qb10;

  assign cur   = {rem, z[ZW-1 -: 8]};
  assign qprod = 24'(cur) * 24'd1639;
  assign qb    = qprod[21:14];
  assign qb10  = 12'(qb) * 12'd10;

  assign pitch = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= D_IDLE;
      status <= '0;
    end else begin
      status <= '0;
      unique case (st)
        D_IDLE: begin
          if (go) begin
            z     <= ZW'(scale);
            steps <= '0;
            if (scale == 32'd0) begin
              status <= '{done: 1'b1, ok: 1'b0};
            end else begin
              st <= D_CHECK;
            end
          end
        end
        D_CHECK: begin
          if (over) begin
            if (exhausted) begin
              status <= '{done: 1'b1, ok: 1'b0};
              st     <= D_IDLE;
            end else begin
              bcnt <= BW'(NB - 1);
              rem  <= 4'd0;
              st   <= D_DIV;
            end
          end else if (under) begin
            if (exhausted) begin
              status <= '{done: 1'b1, ok: 1'b0};
              st     <= D_IDLE;
            end else begin
              z     <= ZW'({z, 3'b000}) + ZW'({z, 1'b0});
              steps <= steps + SW'(1);
            end
          end else begin
            status <= '{done: 1'b1, ok: (z != '0)};
            st     <= D_IDLE;
          end
        end
        D_DIV: begin
          z   <= {z[ZW-9:0], qb};
          rem <= 4'(cur - qb10);
          if (bcnt == '0) begin
            steps <= steps + SW'(1);
            st    <= D_CHECK;
          end else begin
            bcnt <= bcnt - BW'(1);
          end
        end
        default: st <= D_IDLE;
      endcase
    end
  end

endmodule

### rtl/gps_lane.sv
`timescale 1ns / 1ps
module gps_lane import gps_pkg::*; #(
  parameter int  ZW = 40,
  parameter int  FRAC_BITS = 16,
  parameter bit  FIRST_NEG = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [DIFF_W-1:0]    diff,
  input  logic [ZW-1:0]        pitch,
  input  logic [7:0]           catch_range,
  output lane_status_t         status,
  output logic signed [ZW+1:0] shift
);

  localparam int SHW = ZW + 2;
  localparam int LW  = 8 + FRAC_BITS;

  logic              run;
  logic              pend;
  logic [5:0]        cnt;
  logic [DIFF_W-1:0] mag;
  logic              neg;
  logic [ZW-1:0]     rem;

  // Restoring remainder step, one dividend bit per cycle.
  logic [ZW:0] t;
  assign t = {rem, mag[DIFF_W-1]};

  // Candidate offsets to the nearest grid lines.
  logic signed [SHW-1:0] r;
  logic signed [SHW-1:0] zs;
  logic signed [SHW-1:0] c1;
  logic signed [SHW-1:0] c2;
  logic [SHW-1:0]        a0;
  logic [SHW-1:0]        a1;
  logic [SHW-1:0]        a2;
  logic [SHW-1:0]        lim;

  assign zs  = $signed({2'b00, pitch});
  assign r   = neg ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
  assign c1  = FIRST_NEG ? r - zs : r + zs;
  assign c2  = FIRST_NEG ? r + zs : r - zs;
  assign a0  = r[SHW-1]  ? SHW'(-r)  : SHW'(r);
  assign a1  = c1[SHW-1] ? SHW'(-c1) : SHW'(c1);
  assign a2  = c2[SHW-1] ? SHW'(-c2) : SHW'(c2);
  assign lim = SHW'(LW'(catch_range) << FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      pend   <= 1'b0;
      status <= '0;
    end else begin
      status <= '0;
      if (go) begin
        mag  <= diff[DIFF_W-1] ? DIFF_W'(-$signed(diff)) : diff;
        neg  <= diff[DIFF_W-1];
        rem  <= '0;
        cnt  <= 6'(DIFF_W);
        run  <= 1'b1;
      end else if (run) begin
        rem <= (t >= {1'b0, pitch}) ? ZW'(t - {1'b0, pitch}) : ZW'(t);
        mag <= {mag[DIFF_W-2:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          pend <= 1'b1;
        end
      end else if (pend) begin
        // Try the line itself first, then the two neighbors in lane order.
        pend <= 1'b0;
        if (a0 < lim) begin
          status <= '{done: 1'b1, found: 1'b1};
          shift  <= r;
        end else if (a1 < lim) begin
          status <= '{done: 1'b1, found: 1'b1};
          shift  <= c1;
        end else if (a2 < lim) begin
          status <= '{done: 1'b1, found: 1'b1};
          shift  <= c2;
        end else begin
          status <= '{done: 1'b1, found: 1'b0};
          shift  <= r;
        end
      end
    end
  end

endmodule

### rtl/grid_point_snap.sv
`timescale 1ns / 1ps
// Snaps a point onto a decimal view grid.
// Input word: point_x/y, view_scale and offset_x/y, taken at a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Result word: snapped_x/y and caught, shown for one cycle while done is high;
// the receiver cannot stall, so the result must be taken in that cycle.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 is
// max_spacing, 1 is catch_range) at a clock edge; write only while idle.
// Sequence: when the scale is already inside the window, the word passes
// through capture, the window check, the remainder lanes (load, 33
// bit-serial remainder steps, shift choice) and the merge. Each multiply by
// ten adds a window step; each divide by ten adds a decision step and one
// byte of the pitch per cycle. A zero scale returns straight after capture,
// with no search; a failed search returns once the steps run out. One item
// is in flight at a time; busy drops with done, so the next word can be
// taken in the cycle that carries the result.
// Reset: synchronous, active high; clears the sequencer and loads
// max_spacing 200 and catch_range 8. No memories, no clearing pass.
module grid_point_snap import gps_pkg::*; #(
  parameter int MAX_DECADE_STEPS = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] view_scale,
  input  logic [31:0] offset_x,
  input  logic [31:0] offset_y,
  output logic        done,
  output logic [31:0] snapped_x,
  output logic [31:0] snapped_y,
  output logic        caught,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int ZMIN = (FRAC_BITS + 20 > 33) ? FRAC_BITS + 20 : 33;
  localparam int NB   = (ZMIN + 7) / 8;
  localparam int ZW   = NB * 8;
  localparam int SHW  = ZW + 2;
  localparam int OW   = ZW + 3;

  top_state_t  st;
  logic [15:0] max_spacing;
  logic [7:0]  catch_range;
  logic [31:0] px, py, ox, oy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_spacing <= 16'd200;
      catch_range <= 8'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SPACING: max_spacing <= cfg_data;
        REG_CATCH_RANGE: catch_range <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  dec_status_t   dec_st;
  logic [ZW-1:0] pitch;
  logic          dec_go;

  assign dec_go = start && !busy;

  gps_decade #(
    .MAX_STEPS(MAX_DECADE_STEPS), .FRAC_BITS(FRAC_BITS), .NB(NB), .ZW(ZW)
  ) u_decade (
    .clk, .rst, .go(dec_go), .scale(view_scale), .max_spacing,
    .status(dec_st), .pitch
  );

  // One lane per axis.
  lane_status_t          lx_st, ly_st;
  logic signed [SHW-1:0] sx, sy;
  logic                  lane_go;
  logic [DIFF_W-1:0]     dx, dy;

  assign lane_go = dec_st.done && dec_st.ok;
  assign dx = DIFF_W'($signed(px)) - DIFF_W'($signed(ox));
  assign dy = DIFF_W'($signed(py)) - DIFF_W'($signed(oy));

  gps_lane #(.ZW(ZW), .FRAC_BITS(FRAC_BITS), .FIRST_NEG(1'b1)) u_lane_x (
    .clk, .rst, .go(lane_go), .diff(dx), .pitch, .catch_range,
    .status(lx_st), .shift(sx)
  );

  gps_lane #(.ZW(ZW), .FRAC_BITS(FRAC_BITS), .FIRST_NEG(1'b0)) u_lane_y (
    .clk, .rst, .go(lane_go), .diff(dy), .pitch, .catch_range,
    .status(ly_st), .shift(sy)
  );

  // Merge: move the point by both shifts and saturate.
  logic signed [OW-1:0] mx, my;
  logic [31:0]          satx, saty;

  assign mx = OW'($signed(px)) - OW'(sx);
  assign my = OW'($signed(py)) - OW'(sy);

  always_comb begin
    if (mx[OW-1:31] == '0 || mx[OW-1:31] == '1) begin
      satx = mx[31:0];
    end else begin
      satx = mx[OW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    if (my[OW-1:31] == '0 || my[OW-1:31] == '1) begin
      saty = my[31:0];
    end else begin
      saty = my[OW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  assign busy = (st != S_IDLE);

  // Sequencer and result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      done   <= 1'b0;
      caught <= 1'b0;
    end else begin
      done   <= 1'b0;
      caught <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (start) begin
            px <= point_x;
            py <= point_y;
            ox <= offset_x;
            oy <= offset_y;
            st <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (dec_st.done) begin
            if (dec_st.ok) begin
              st <= S_REM;
            end else begin
              snapped_x <= px;
              snapped_y <= py;
              done      <= 1'b1;
              st        <= S_IDLE;
            end
          end
        end
        S_REM: begin
          if (lx_st.done) begin
            if (lx_st.found && ly_st.found) begin
              snapped_x <= satx;
              snapped_y <= saty;
              caught    <= 1'b1;
            end else begin
              snapped_x <= px;
              snapped_y <= py;
            end
            done <= 1'b1;
            st   <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/gps_checker.sv
`timescale 1ns / 1ps
module gps_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic caught
);

  // A result word only appears once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // An accepted word makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accept without busy");

  // The caught flag only accompanies a result word.
  a_caught_done: assert property (@(posedge clk) disable iff (rst) caught |-> done)
    else $error("caught without done");

  // Results never come back to back.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held two cycles");

  // Reset leaves the block idle and quiet.
  a_reset: assert property (@(posedge clk) rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind grid_point_snap gps_checker u_gps_checker (.*);

### dv/grid_point_snap_checker.sv
`timescale 1ns / 1ps
module grid_point_snap_checker import gps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] point_x,
  input  logic [31:0] point_y,
  input  logic [31:0] view_scale,
  input  logic [31:0] offset_x,
  input  logic [31:0] offset_y,
  input  logic        done,
  input  logic [31:0] snapped_x,
  input  logic [31:0] snapped_y,
  input  logic        caught,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          catches_seen
);

  localparam int MAX_STEPS = 12;
  localparam int FRAC = 16;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        hit;
  } snap_word_t;

  logic [15:0] spacing_q;
  logic [7:0]  range_q;
  snap_word_t  snap_queue[$];

  assign pending = snap_queue.size();

  // Clamp a wide value to the signed 32-bit range.
  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Try no shift, then dir*pitch, then -dir*pitch.
  function automatic bit try_shift(longint r, longint z, longint lim, longint dir,
                                   output longint res);
    res = 0;
    if (mag(r) < lim) begin res = r; return 1; end
    if (mag(r + dir * z) < lim) begin res = r + dir * z; return 1; end
    if (mag(r - dir * z) < lim) begin res = r - dir * z; return 1; end
    return 0;
  endfunction

  // Expected snap result for one input word under the current registers.
  function automatic snap_word_t snap_point(logic [31:0] px32, logic [31:0] py32,
                                            logic [31:0] sc, logic [31:0] ox32,
                                            logic [31:0] oy32);
    longint px, py, ox, oy, z, hi, lo, lim, rx, ry, sx, sy;
    bit ok;
    snap_word_t w;
    px = longint'(signed'(px32));
    py = longint'(signed'(py32));
    ox = longint'(signed'(ox32));
    oy = longint'(signed'(oy32));
    z = longint'({32'd0, sc});
    hi = longint'(spacing_q) <<< FRAC;
    lo = (longint'(spacing_q / 10) - 1) <<< FRAC;
    lim = longint'(range_q) <<< FRAC;
    w = '{sx: px32, sy: py32, hit: 1'b0};
    ok = 0;
    if (z != 0) begin
      for (int n = 0; ; n++) begin
        if (z > hi) begin
          if (n >= MAX_STEPS) break;
          z = z / 10;
        end else if (z < lo) begin
          if (n >= MAX_STEPS) break;
          z = z * 10;
        end else begin
          ok = 1;
          break;
        end
      end
    end
    if (!ok || z <= 0) return w;
    rx = (px - ox) % z;
    ry = (py - oy) % z;
    if (try_shift(rx, z, lim, -1, sx) && try_shift(ry, z, lim, 1, sy)) begin
      w.sx = clamp32(px - sx);
      w.sy = clamp32(py - sy);
      w.hit = 1'b1;
    end
    return w;
  endfunction

  // Track registers, predict on accepted words, compare results.
  always @(posedge clk) begin
    snap_word_t want;
    if (rst) begin
      spacing_q <= 16'd200;
      range_q <= 8'd8;
      fail_count <= 0;
      words_checked <= 0;
      catches_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MAX_SPACING) spacing_q <= cfg_data;
        else range_q <= cfg_data[7:0];
      end
      if (done) begin
        if (snap_queue.size() == 0) begin
          $display("%0t: result word with none expected: %h %h %b", $time,
                   snapped_x, snapped_y, caught);
          fail_count <= fail_count + 1;
        end else begin
          want = snap_queue.pop_front();
          words_checked <= words_checked + 1;
          if (caught) catches_seen <= catches_seen + 1;
          if (want.sx !== snapped_x || want.sy !== snapped_y || want.hit !== caught) begin
            $display("%0t: mismatch expected x=%h y=%h c=%b actual x=%h y=%h c=%b",
                     $time, want.sx, want.sy, want.hit, snapped_x, snapped_y, caught);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        snap_queue.push_back(snap_point(point_x, point_y, view_scale, offset_x, offset_y));
    end
  end

endmodule

### dv/grid_point_snap_tb.sv
`timescale 1ns / 1ps
module grid_point_snap_tb import gps_pkg::*;;

  localparam longint CYCLE_LIMIT = 64'd3000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] point_x = '0;
  logic [31:0] point_y = '0;
  logic [31:0] view_scale = '0;
  logic [31:0] offset_x = '0;
  logic [31:0] offset_y = '0;
  logic        done;
  logic [31:0] snapped_x;
  logic [31:0] snapped_y;
  logic        caught;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_MAX_SPACING;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          words_checked;
  int          catches_seen;
  longint      cycles = 0;

  always #1 clk = ~clk;

  grid_point_snap u_dut (.*);

  grid_point_snap_checker u_checker (.*);

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("grid_point_snap_tb: errors");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] sc,
                           logic [31:0] ox, logic [31:0] oy);
    point_x <= px;
    point_y <= py;
    view_scale <= sc;
    offset_x <= ox;
    offset_y <= oy;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
  endtask

  task automatic idle_gap();
    int k;
    k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(10, 150);
    repeat (k) @(posedge clk);
  endtask

  // Wait for all results, then let the block settle before touching registers.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Scale near the grid pitch so that remainders are often small.
  function automatic logic [31:0] pick_scale();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'd0;
    return $urandom_range(1, 2000) * ($urandom_range(0, 1) ? 32'd65536 : 32'd6554);
  endfunction

  function automatic logic [31:0] near_grid(logic [31:0] base);
    return base + $urandom_range(0, 60) * 32'd65536 + $urandom_range(0, 65535)
           - 32'd30 * 32'd65536;
  endfunction

  initial begin
    logic [15:0] spacing_set[5];
    logic [7:0]  range_set[5];
    logic [31:0] ox, oy;
    spacing_set = '{16'd200, 16'd20, 16'd65535, 16'd100, 16'd1000};
    range_set = '{8'd8, 8'd0, 8'd255, 8'd20, 8'd3};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: extremes of each field, zero scale, huge and tiny scales.
    send_word(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(32'h7fffffff, 32'h80000000, 32'h0064_0000, 32'h80000000, 32'h7fffffff);
    send_word(32'h80000000, 32'h7fffffff, 32'h0064_0000, 32'h7fffffff, 32'h80000000);
    send_word(32'h0003_0000, 32'hfffd_0000, 32'h0064_0000, 32'h0, 32'h0);
    send_word(32'h0062_0000, 32'h0061_0000, 32'h0064_0000, 32'h0, 32'h0);
    send_word(32'hff9e_0000, 32'h0067_0000, 32'h0064_0000, 32'h0, 32'h0);
    send_word(32'h0032_0000, 32'h0002_0000, 32'h0064_0000, 32'h0, 32'h0);
    send_word(32'h0002_0000, 32'h0032_0000, 32'h0064_0000, 32'h0, 32'h0);
    send_word(32'h1234_5678, 32'h8765_4321, 32'hffffffff, 32'h1, 32'hffffffff);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0000_0001, 32'h0, 32'h0);
    send_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
    send_word(32'h7ffe_0000, 32'h7ffe_0000, 32'h000a_0000, 32'h0, 32'h0);
    send_word(32'h5555_5555, 32'haaaa_aaaa, 32'h0ccc_cccc, 32'haaaa_aaaa, 32'h5555_5555);
    drain();

    // Tiny spacing turns off the lower bound of the window.
    write_reg(REG_MAX_SPACING, 16'd5);
    write_reg(REG_CATCH_RANGE, 16'd2);
    send_word(32'h0001_0000, 32'h0, 32'h0000_0003, 32'h0, 32'h0);
    send_word(32'h0003_0000, 32'h0, 32'h0003_0000, 32'h0, 32'h0);
    send_word(32'h0, 32'h0, 32'h0000_0001, 32'h0, 32'h0);
    drain();

    // Random phases across register settings.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MAX_SPACING, spacing_set[ph]);
      write_reg(REG_CATCH_RANGE, {8'd0, range_set[ph]});
      for (int i = 0; i < 250; i++) begin
        ox = $urandom();
        oy = $urandom();
        if ($urandom_range(0, 3) != 0)
          send_word(near_grid(ox), near_grid(oy), pick_scale(), ox, oy);
        else
          send_word($urandom(), $urandom(), pick_scale(), ox, oy);
        idle_gap();
        if (ph == 2 && i == 100) while (pending != 0) @(posedge clk);
      end
      drain();
    end

    $display("Checked %0d result words, %0d of them snapped, over six register settings.",
             words_checked, catches_seen);
    if (fail_count == 0) begin
      $display("grid_point_snap_tb: clean");
    end else begin
      $display("grid_point_snap_tb: errors");
    end
    $finish;
  end

endmodule

### sim.f
rtl/gps_pkg.sv
rtl/gps_decade.sv
rtl/gps_lane.sv
rtl/grid_point_snap.sv
rtl/gps_checker.sv
dv/grid_point_snap_checker.sv
dv/grid_point_snap_tb.sv
